[design/stt_pkg.sv]
// ============================================================================
// Software timer table package
// Shared constants, payload structs, event codes and controller types.
// ============================================================================
package stt_pkg;

    // Table geometry.
    localparam int TABLE_SLOTS = 16;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int USED_W      = $clog2(TABLE_SLOTS + 1);
    localparam int WORD_W      = 32;

    // Request codes.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Event codes carried in each result.
    typedef enum logic [2:0] {
        EV_STARTED = 3'd0,
        EV_FULL    = 3'd1,
        EV_ZERO    = 3'd2,
        EV_EXPIRED = 3'd3,
        EV_IDLE    = 3'd4
    } t_event;

    typedef struct packed {
        logic                   req_type;
        logic [HANDLE_BITS-1:0] timer_handle;
        logic [WORD_W-1:0]      delay_amount;
    } t_in_item;

    typedef struct packed {
        t_event                 event_kind;
        logic [HANDLE_BITS-1:0] expired_handle;
        logic [WORD_W-1:0]      tick_count;
        logic                   last_of_run;
    } t_out_item;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic visit;
        logic final_emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_is_start;
        logic used_zero;
        logic scan_last;
        logic visit_hold;
        logic out_free;
    } t_status;

endpackage

[design/stt_ctrl.sv]
// ============================================================================
// Software timer table controller
// Sequences acceptance, the entry scan and the closing result of a request.
// ============================================================================
module stt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  stt_pkg::t_status i_status,
    output stt_pkg::t_cmd   o_cmd,
    output logic            o_in_stall
);
    import stt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.req_is_start || i_status.used_zero) begin
                        n_state = ST_FINAL;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!i_status.visit_hold && i_status.scan_last) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // No request is taken while reset is held.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = !i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            ST_SCAN: begin
                o_cmd.visit = !i_status.visit_hold;
            end
            ST_FINAL: begin
                o_cmd.final_emit = i_status.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

[design/stt_dp.sv]
// ============================================================================
// Software timer table datapath
// Timer entries, tick counter, step register, pending result and output stage.
// ============================================================================
module stt_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stt_pkg::t_cmd      i_cmd,
    input  stt_pkg::t_in_item  i_in_data,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_out_stall,
    output stt_pkg::t_status   o_status,
    output logic               o_out_valid,
    output stt_pkg::t_out_item o_out_data
);
    import stt_pkg::*;

    // Timer entries, valid only below the fill count.
    logic [HANDLE_BITS-1:0] r_handle [TABLE_SLOTS];
    logic [WORD_W-1:0]      r_delay  [TABLE_SLOTS];
    logic [WORD_W-1:0]      r_cursor [TABLE_SLOTS];
    logic                   r_fresh  [TABLE_SLOTS];

    logic [USED_W-1:0]      r_used;
    logic [IDX_W-1:0]       r_idx;
    logic [WORD_W-1:0]      r_ticks;
    logic [WORD_W-1:0]      r_step;

    // Result held back until we know whether it closes the run.
    logic                   r_pend_valid;
    t_event                 r_pend_kind;
    logic [HANDLE_BITS-1:0] r_pend_handle;

    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   table_full;
    logic                   start_ok;
    logic [IDX_W-1:0]       wr_idx;
    logic [WORD_W:0]        cur_sum;
    logic [WORD_W-1:0]      cur_next;
    logic                   expire;
    logic                   out_free;
    logic                   emit_mid;
    logic                   load_out;
    t_out_item              out_next;

    assign table_full = (r_used >= USED_W'(TABLE_SLOTS));
    assign start_ok   = (i_in_data.delay_amount != '0) && !table_full;
    assign wr_idx     = r_used[IDX_W-1:0];

    // Saturating cursor advance for the visited entry.
    assign cur_sum  = {1'b0, r_cursor[r_idx]} + {1'b0, r_step};
    assign cur_next = cur_sum[WORD_W] ? {WORD_W{1'b1}} : cur_sum[WORD_W-1:0];
    assign expire   = !r_fresh[r_idx] && (cur_next >= r_delay[r_idx]);

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_mid = i_cmd.visit && expire && r_pend_valid;
    assign load_out = emit_mid || i_cmd.final_emit;

    always_comb begin
        out_next.tick_count = r_ticks;
        if (i_cmd.final_emit) begin
            out_next.last_of_run = 1'b1;
            if (r_pend_valid) begin
                out_next.event_kind     = r_pend_kind;
                out_next.expired_handle = r_pend_handle;
            end else begin
                out_next.event_kind     = EV_IDLE;
                out_next.expired_handle = '0;
            end
        end else begin
            out_next.last_of_run    = 1'b0;
            out_next.event_kind     = r_pend_kind;
            out_next.expired_handle = r_pend_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in_data.req_type == REQ_START && start_ok) begin
            r_handle[wr_idx] <= i_in_data.timer_handle;
            r_delay[wr_idx]  <= i_in_data.delay_amount;
            r_cursor[wr_idx] <= '0;
            r_fresh[wr_idx]  <= 1'b1;
        end else if (i_cmd.visit) begin
            if (r_fresh[r_idx]) begin
                r_fresh[r_idx] <= 1'b0;
            end else begin
                r_cursor[r_idx] <= cur_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_ticks      <= '0;
            r_step       <= 32'd1;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            r_out_valid <= load_out || (r_out_valid && i_out_stall);
            if (i_cmd.accept) begin
                r_idx <= '0;
                if (i_in_data.req_type == REQ_START) begin
                    r_pend_valid <= 1'b1;
                    if (start_ok) begin
                        r_used <= r_used + USED_W'(1);
                    end
                end else begin
                    r_ticks      <= r_ticks + WORD_W'(1);
                    r_pend_valid <= 1'b0;
                end
            end
            if (i_cmd.visit) begin
                r_idx <= r_idx + IDX_W'(1);
                if (expire) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (i_cmd.final_emit) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Pending payload needs no reset: it is qualified by its valid bit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_in_data.delay_amount == '0) begin
                r_pend_kind   <= EV_ZERO;
                r_pend_handle <= '0;
            end else if (table_full) begin
                r_pend_kind   <= EV_FULL;
                r_pend_handle <= '0;
            end else begin
                r_pend_kind   <= EV_STARTED;
                r_pend_handle <= i_in_data.timer_handle;
            end
        end else if (i_cmd.visit && expire) begin
            r_pend_kind   <= EV_EXPIRED;
            r_pend_handle <= r_handle[r_idx];
        end
        if (load_out) begin
            r_out <= out_next;
        end
    end

    assign o_status.req_is_start = (i_in_data.req_type == REQ_START);
    assign o_status.used_zero    = (r_used == '0);
    assign o_status.scan_last    = (USED_W'(r_idx) == (r_used - USED_W'(1)));
    assign o_status.visit_hold   = expire && r_pend_valid && !out_free;
    assign o_status.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/software_timer_table_tick_unit.sv]
// ============================================================================
// Software timer table tick unit
// A table of software timers advanced by a hardware tick request.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ------------------------------
//  in        input      i_in_valid / o_in_stall     t_in_item (type, handle, delay)
//  out       output     o_out_valid / i_out_stall   t_out_item (event, handle, ...)
//  cfg       input      i_cfg_valid / o_cfg_ready   tick_step, 32 bits
//
//  A start request is accepted and then presents its result in the closing state.
//  A tick request is accepted, then visits each timer in the table in turn on the
//  shared cursor adder (an empty table skips the scan), and then closes with a result.
//  Reset is synchronous and active low; it empties the table, zeroes the tick
//  counter and sets tick_step to one. The input is stalled while reset is held.
//  A stalled output holds the scan only when a second expiry must be passed on.
//
module software_timer_table_tick_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  stt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output stt_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import stt_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The step register may be written at any time the unit is idle, so the
    // configuration channel is always ready.
    assign o_cfg_ready = 1'b1;

    // The controller owns sequencing and the input stall.
    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the table, counters and the output register.
    stt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
